FILE: hw/rtl/pwbl_pkg.sv
// Package for the pulse-width boot link receiver.
// Holds the item types, the command type passed from front to back and the register map.
// Has no dependencies.
package pwbl_pkg;

  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CODE_BITS = 8;
  localparam int unsigned BCNT_BITS = $clog2(BYTE_BITS + 1);

  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned DATA_BITS = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_REPLY_ONE = 2'd1;
  localparam logic [1:0] REG_REPLY_ZRO = 2'd2;

  localparam logic [TIME_BITS-1:0] TIMEOUT_RST   = TIME_BITS'(32768);
  localparam logic [CODE_BITS-1:0] REPLY_ONE_RST = CODE_BITS'(8'hAA);
  localparam logic [CODE_BITS-1:0] REPLY_ZRO_RST = CODE_BITS'(8'hAB);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                 op;
    logic                 edge_rising;
    logic [TIME_BITS-1:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic                 txd_level;
    logic                 byte_done;
    logic [7:0]           byte_value;
    logic                 byte_matched;
    logic                 calibrated;
    logic                 timed_out;
    logic [TIME_BITS-1:0] bit_threshold;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_FALL = 2'd1,
    CMD_RISE = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [TIME_BITS-1:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] timeout_ticks;
    logic [CODE_BITS-1:0] reply_one_code;
    logic [CODE_BITS-1:0] reply_zero_code;
  } cfg_t;

endpackage

FILE: hw/rtl/pwbl_front.sv
// Front part: accepts input items, classifies them as tick, falling or rising edge
// and holds them in a two-entry queue for the back part. Depends on pwbl_pkg.
module pwbl_front import pwbl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.stamp = in_item_i.capture_time;
    if (in_item_i.op == OP_TICK) begin
      cmd_new.kind = CMD_TICK;
    end else if (in_item_i.edge_rising) begin
      cmd_new.kind = CMD_RISE;
    end else begin
      cmd_new.kind = CMD_FALL;
    end
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= cmd_new;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !cmd_pop_i) |=> in_stall_o) else $error("full queue released");

endmodule

FILE: hw/rtl/pwbl_back.sv
// Back part: runs calibration, bit decoding, reply sequencing and the watchdog,
// one command per cycle unless stalled, into an output register. Depends on pwbl_pkg.
module pwbl_back import pwbl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    PH_CAL_FALL0 = 4'd0,
    PH_CAL_RISE0 = 4'd1,
    PH_CAL_FALL1 = 4'd2,
    PH_CAL_RISE1 = 4'd3,
    PH_DATA      = 4'd4,
    PH_REPLY_LOW = 4'd5,
    PH_REPLY_REL = 4'd6,
    PH_REPLY_END = 4'd7,
    PH_REPLY_FIN = 4'd8
  } phase_e;

  phase_e                phase_q, phase_d;
  logic                  exp_rise_q, exp_rise_d;
  logic [TIME_BITS-1:0]  stamp_q, stamp_d;
  logic [TIME_BITS-1:0]  short_q, short_d;
  logic [TIME_BITS-1:0]  thresh_q, thresh_d;
  logic [BYTE_BITS-1:0]  shift_q, shift_d;
  logic [BCNT_BITS-1:0]  bits_q, bits_d, bits_dec;
  logic                  reply_q, reply_d;
  logic                  txd_q, txd_d;
  logic                  dog_run_q, dog_run_d;
  logic [TIME_BITS-1:0]  dog_cnt_q, dog_cnt_d, dog_inc;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  logic                  exec, is_edge, edge_ok;
  logic                  done, matched, expired;
  logic [TIME_BITS-1:0]  width;
  logic [TIME_BITS:0]    sum;
  logic [CODE_BITS-1:0]  code;

  // Execute whenever the output slot is free or being emptied this cycle
  assign exec      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = exec;

  assign is_edge  = (cmd_i.kind != CMD_TICK);
  assign edge_ok  = is_edge && ((cmd_i.kind == CMD_RISE) == exp_rise_q);
  assign width    = cmd_i.stamp - stamp_q;
  assign sum      = {1'b0, width} + {1'b0, short_q};
  assign dog_inc  = dog_cnt_q + TIME_BITS'(1);
  assign bits_dec = (bits_q == '0) ? '0 : bits_q - BCNT_BITS'(1);

  always_comb begin
    phase_d    = phase_q;
    exp_rise_d = exp_rise_q;
    stamp_d    = stamp_q;
    short_d    = short_q;
    thresh_d   = thresh_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    reply_d    = reply_q;
    txd_d      = txd_q;
    dog_run_d  = dog_run_q;
    dog_cnt_d  = dog_cnt_q;
    done       = 1'b0;
    matched    = 1'b0;
    expired    = 1'b0;
    code       = CODE_BITS'(shift_d);

    if (edge_ok) begin
      dog_run_d = 1'b1;
      dog_cnt_d = '0;
      case (phase_q)
        PH_CAL_FALL0, PH_CAL_FALL1: begin
          stamp_d    = cmd_i.stamp;
          exp_rise_d = 1'b1;
          phase_d    = (phase_q == PH_CAL_FALL0) ? PH_CAL_RISE0 : PH_CAL_RISE1;
        end
        PH_CAL_RISE0: begin
          short_d    = width;
          exp_rise_d = 1'b0;
          phase_d    = PH_CAL_FALL1;
        end
        PH_CAL_RISE1: begin
          thresh_d   = sum[TIME_BITS:1];
          exp_rise_d = 1'b0;
          dog_run_d  = 1'b0;
          phase_d    = PH_DATA;
        end
        PH_DATA: begin
          if (!exp_rise_q) begin
            stamp_d    = cmd_i.stamp;
            exp_rise_d = 1'b1;
          end else begin
            exp_rise_d = 1'b0;
            // LSB first: new bit enters at the top
            shift_d = {(width < thresh_q), shift_q[BYTE_BITS-1:1]};
            bits_d  = bits_dec;
            code    = CODE_BITS'(shift_d);
            if (bits_dec == '0) begin
              done      = 1'b1;
              dog_run_d = 1'b0;
              bits_d    = BCNT_BITS'(BYTE_BITS);
              if (code == cfg_i.reply_one_code) begin
                reply_d = 1'b1;
                phase_d = PH_REPLY_LOW;
                matched = 1'b1;
              end else if (code == cfg_i.reply_zero_code) begin
                reply_d = 1'b0;
                phase_d = PH_REPLY_LOW;
                matched = 1'b1;
              end
            end
          end
        end
        PH_REPLY_LOW: begin
          txd_d      = 1'b0;
          exp_rise_d = 1'b1;
          phase_d    = PH_REPLY_REL;
        end
        PH_REPLY_REL: begin
          if (reply_q) txd_d = 1'b1;
          exp_rise_d = 1'b0;
          phase_d    = PH_REPLY_END;
        end
        PH_REPLY_END: begin
          txd_d      = 1'b1;
          exp_rise_d = 1'b1;
          phase_d    = PH_REPLY_FIN;
        end
        PH_REPLY_FIN: begin
          exp_rise_d = 1'b0;
          bits_d     = BCNT_BITS'(BYTE_BITS);
          dog_run_d  = 1'b0;
          phase_d    = PH_DATA;
        end
        default: begin
          phase_d = PH_CAL_FALL0;
        end
      endcase
    end else if (!is_edge && dog_run_q) begin
      dog_cnt_d = dog_inc;
      if (dog_inc >= cfg_i.timeout_ticks) begin
        // Drop back to calibration; leave txd, byte and threshold alone
        phase_d    = PH_CAL_FALL0;
        exp_rise_d = 1'b0;
        bits_d     = BCNT_BITS'(BYTE_BITS);
        dog_run_d  = 1'b0;
        dog_cnt_d  = '0;
        expired    = 1'b1;
      end
    end

    out_d.txd_level     = txd_d;
    out_d.byte_done     = done;
    out_d.byte_value    = 8'(shift_d);
    out_d.byte_matched  = matched;
    out_d.calibrated    = (phase_d inside {[PH_DATA:PH_REPLY_FIN]});
    out_d.timed_out     = expired;
    out_d.bit_threshold = thresh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CAL_FALL0;
      exp_rise_q  <= 1'b0;
      stamp_q     <= '0;
      short_q     <= '0;
      thresh_q    <= '0;
      shift_q     <= '0;
      bits_q      <= BCNT_BITS'(BYTE_BITS);
      reply_q     <= 1'b0;
      txd_q       <= 1'b1;
      dog_run_q   <= 1'b0;
      dog_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        phase_q    <= phase_d;
        exp_rise_q <= exp_rise_d;
        stamp_q    <= stamp_d;
        short_q    <= short_d;
        thresh_q   <= thresh_d;
        shift_q    <= shift_d;
        bits_q     <= bits_d;
        reply_q    <= reply_d;
        txd_q      <= txd_d;
        dog_run_q  <= dog_run_d;
        dog_cnt_q  <= dog_cnt_d;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_match_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.byte_matched |-> out_q.byte_done)
    else $error("match without completed byte");
  a_timeout_uncal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.timed_out |-> !out_q.calibrated)
    else $error("timeout left block calibrated");
  a_timeout_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && expired |=> phase_q == PH_CAL_FALL0 && !dog_run_q && !exp_rise_q)
    else $error("timeout did not restart calibration");
  a_bits_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q != '0) else $error("bit counter reached zero");

endmodule

FILE: hw/rtl/pulse_width_boot_link_receiver.sv
// Top level of the pulse-width boot link receiver: APB register file, front queue
// and back engine. Depends on pwbl_pkg, pwbl_front and pwbl_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one item per
//   accepted cycle: either a clock tick (op = 1) that advances the watchdog, or
//   a line edge with its polarity and captured timer value (op = 0).
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly one
//   item per input item, in order: TXD level, byte completion and match flags,
//   the shift register, calibration state, watchdog expiry and the threshold.
//   When the output is free, the item is written into the two-entry queue at
//   its accepting edge, and the back engine then lands its result in the
//   output register, where out_valid_o rises. Throughput is one item per cycle
//   while the output is not stalled; the limit is the back engine, which retires
//   one command per cycle through its single state update.
//   When the receiver stalls, the output register holds its item, the back
//   engine waits, and the queue absorbs up to two further items before
//   in_stall_o rises.
//   Reset clears the queue and output register, returns the engine to the first
//   calibration edge with TXD released high, and loads the register defaults
//   (timeout 32768 ticks, reply codes 0xAA and 0xAB).
//   Write registers (4-byte spaced) only while no item is in flight.
module pulse_width_boot_link_receiver import pwbl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  // Result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  // Register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;

  // Register file: write on the access phase, always ready
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks   <= TIMEOUT_RST;
      cfg_q.reply_one_code  <= REPLY_ONE_RST;
      cfg_q.reply_zero_code <= REPLY_ZRO_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TIMEOUT:   cfg_q.timeout_ticks   <= pwdata[TIME_BITS-1:0];
        REG_REPLY_ONE: cfg_q.reply_one_code  <= pwdata[CODE_BITS-1:0];
        REG_REPLY_ZRO: cfg_q.reply_zero_code <= pwdata[CODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    case (reg_idx)
      REG_TIMEOUT:   prdata = DATA_BITS'(cfg_q.timeout_ticks);
      REG_REPLY_ONE: prdata = DATA_BITS'(cfg_q.reply_one_code);
      REG_REPLY_ZRO: prdata = DATA_BITS'(cfg_q.reply_zero_code);
      default:       prdata = '0;
    endcase
  end

  // Front: classify and queue
  pwbl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: decode pulses, sequence replies, run the watchdog
  pwbl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: tb/pwbl_checker.sv
`timescale 1ns / 100ps
// Result checker for the pulse-width boot link receiver: watches both item channels and
// the register port, predicts each result item and compares it field by field.
// Depends on pwbl_pkg only.
module pwbl_link_checker import pwbl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_item_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [ADDR_BITS-1:0] paddr_i,
  input  logic [DATA_BITS-1:0] pwdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   bytes_o,
  output int                   replies_o,
  output int                   expiries_o
);

  typedef enum logic [3:0] {
    PH_CAL_FALL1    = 4'd0,
    PH_CAL_RISE1    = 4'd1,
    PH_CAL_FALL2    = 4'd2,
    PH_CAL_RISE2    = 4'd3,
    PH_DATA         = 4'd4,
    PH_REPLY_FALL   = 4'd5,
    PH_REPLY_RISE   = 4'd6,
    PH_RELEASE_FALL = 4'd7,
    PH_RELEASE_RISE = 4'd8
  } link_phase_e;

  localparam logic [BCNT_BITS-1:0] BITS_FULL = BCNT_BITS'(BYTE_BITS);

  // Shadow of the link state and of the registers
  link_phase_e            phase;
  logic                   want_rise;
  logic [TIME_BITS-1:0]   stamp;
  logic [TIME_BITS-1:0]   short_w;
  logic [TIME_BITS-1:0]   thr;
  logic [TIME_BITS-1:0]   dog_cnt;
  logic [BYTE_BITS-1:0]   shreg;
  logic [BCNT_BITS-1:0]   bits_left;
  logic                   reply_one;
  logic                   txd;
  logic                   dog_on;
  cfg_t                   cfg;

  out_item_t expected_results[$];
  out_item_t fresh;
  out_item_t oldest;

  task automatic back_to_calibration();
    phase     = PH_CAL_FALL1;
    want_rise = 1'b0;
    bits_left = BITS_FULL;
    dog_on    = 1'b0;
    dog_cnt   = '0;
  endtask

  task automatic predict_link_result(input in_item_t it, output out_item_t res);
    logic [TIME_BITS-1:0] width;
    logic [TIME_BITS:0]   sum;
    logic                 done;
    logic                 matched;
    logic                 expired;
    done    = 1'b0;
    matched = 1'b0;
    expired = 1'b0;
    if (it.op == OP_EDGE) begin
      if (it.edge_rising == want_rise) begin
        dog_on  = 1'b1;
        dog_cnt = '0;
        case (phase)
          PH_CAL_FALL1: begin
            stamp     = it.capture_time;
            want_rise = 1'b1;
            phase     = PH_CAL_RISE1;
          end
          PH_CAL_RISE1: begin
            short_w   = it.capture_time - stamp;
            want_rise = 1'b0;
            phase     = PH_CAL_FALL2;
          end
          PH_CAL_FALL2: begin
            stamp     = it.capture_time;
            want_rise = 1'b1;
            phase     = PH_CAL_RISE2;
          end
          PH_CAL_RISE2: begin
            width     = it.capture_time - stamp;
            sum       = {1'b0, width} + {1'b0, short_w};
            thr       = sum[TIME_BITS:1];
            want_rise = 1'b0;
            dog_on    = 1'b0;
            phase     = PH_DATA;
          end
          PH_DATA: begin
            if (!want_rise) begin
              stamp     = it.capture_time;
              want_rise = 1'b1;
            end else begin
              width     = it.capture_time - stamp;
              want_rise = 1'b0;
              shreg     = {width < thr, shreg[BYTE_BITS-1:1]};
              if (bits_left != 0) bits_left = bits_left - 1'b1;
              if (bits_left == 0) begin
                done      = 1'b1;
                dog_on    = 1'b0;
                bits_left = BITS_FULL;
                if (shreg[7:0] == cfg.reply_one_code) begin
                  reply_one = 1'b1;
                  phase     = PH_REPLY_FALL;
                  matched   = 1'b1;
                end else if (shreg[7:0] == cfg.reply_zero_code) begin
                  reply_one = 1'b0;
                  phase     = PH_REPLY_FALL;
                  matched   = 1'b1;
                end
              end
            end
          end
          PH_REPLY_FALL: begin
            txd       = 1'b0;
            want_rise = 1'b1;
            phase     = PH_REPLY_RISE;
          end
          PH_REPLY_RISE: begin
            if (reply_one) txd = 1'b1;
            want_rise = 1'b0;
            phase     = PH_RELEASE_FALL;
          end
          PH_RELEASE_FALL: begin
            txd       = 1'b1;
            want_rise = 1'b1;
            phase     = PH_RELEASE_RISE;
          end
          PH_RELEASE_RISE: begin
            want_rise = 1'b0;
            bits_left = BITS_FULL;
            dog_on    = 1'b0;
            phase     = PH_DATA;
          end
          default: phase = PH_CAL_FALL1;
        endcase
      end
    end else if (dog_on) begin
      dog_cnt = dog_cnt + 1'b1;
      if (dog_cnt >= cfg.timeout_ticks) begin
        back_to_calibration();
        expired = 1'b1;
      end
    end
    res.txd_level     = txd;
    res.byte_done     = done;
    res.byte_value    = shreg[7:0];
    res.byte_matched  = matched;
    res.calibrated    = (phase >= PH_DATA) && (phase <= PH_RELEASE_RISE);
    res.timed_out     = expired;
    res.bit_threshold = thr;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_to_calibration();
      stamp     = '0;
      short_w   = '0;
      thr       = '0;
      shreg     = '0;
      reply_one = 1'b0;
      txd       = 1'b1;
      cfg.timeout_ticks   = TIMEOUT_RST;
      cfg.reply_one_code  = REPLY_ONE_RST;
      cfg.reply_zero_code = REPLY_ZRO_RST;
      expected_results.delete();
      pending_o = 0;
    end else begin
      // Retire the oldest expectation first; latency keeps a new one from matching here
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result item with none expected, expected nothing, got %0h",
                   $time, out_item_i);
        end else begin
          oldest = expected_results.pop_front();
          pending_o--;
          check_field("txd_level",     oldest.txd_level,     out_item_i.txd_level);
          check_field("byte_done",     oldest.byte_done,     out_item_i.byte_done);
          check_field("byte_value",    oldest.byte_value,    out_item_i.byte_value);
          check_field("byte_matched",  oldest.byte_matched,  out_item_i.byte_matched);
          check_field("calibrated",    oldest.calibrated,    out_item_i.calibrated);
          check_field("timed_out",     oldest.timed_out,     out_item_i.timed_out);
          check_field("bit_threshold", oldest.bit_threshold, out_item_i.bit_threshold);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_link_result(in_item_i, fresh);
        if (fresh.byte_done) bytes_o++;
        if (fresh.byte_matched) replies_o++;
        if (fresh.timed_out) expiries_o++;
        expected_results.push_back(fresh);
        pending_o++;
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_TIMEOUT:   cfg.timeout_ticks   = pwdata_i[TIME_BITS-1:0];
          REG_REPLY_ONE: cfg.reply_one_code  = pwdata_i[CODE_BITS-1:0];
          REG_REPLY_ZRO: cfg.reply_zero_code = pwdata_i[CODE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    bytes_o      = 0;
    replies_o    = 0;
    expiries_o   = 0;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Top of the pulse-width boot link receiver testbench: clock, reset, register writes,
// item stimulus and the verdict. Depends on pwbl_pkg, the receiver and pwbl_link_checker.
module tb;
  import pwbl_pkg::*;

  localparam logic FALLING = 1'b0;
  localparam logic RISING  = 1'b1;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] paddr   = '0;
  logic [DATA_BITS-1:0] pwdata  = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  int fail_count;
  int pending;
  int bytes_seen;
  int replies_seen;
  int expiries_seen;

  // Generator state: line timer, calibration unit and the register values in force
  logic [TIME_BITS-1:0] now_t;
  int unsigned          unit_w;
  logic [TIME_BITS-1:0] cur_timeout = TIMEOUT_RST;
  logic [CODE_BITS-1:0] cur_one     = REPLY_ONE_RST;
  logic [CODE_BITS-1:0] cur_zero    = REPLY_ZRO_RST;
  bit                   quiet       = 1'b0;
  bit                   counting    = 1'b1;
  int                   items_sent  = 0;
  int                   holds_asked  = 0;
  int                   holds_served = 0;

  pulse_width_boot_link_receiver uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  pwbl_link_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .bytes_o      (bytes_seen),
    .replies_o    (replies_seen),
    .expiries_o   (expiries_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block wedges or an expectation never drains
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver side: draw a hold-off per result item, then release stall until one is taken.
  // A pending hold request stalls for a long stretch so the queue fills and the input stalls.
  initial begin : result_sink
    int unsigned wait_cycles;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (holds_asked != holds_served) begin
        holds_served++;
        wait_cycles = 300;
      end else begin
        wait_cycles = quiet ? 0 : $urandom_range(0, 9);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // Offer one item after a random gap and hold it until taken. Valid stays high
  // across back-to-back items; it only drops when a gap is drawn.
  task automatic offer(input logic op, input logic rising, input logic [TIME_BITS-1:0] stamp);
    in_item_t    it;
    int unsigned gap;
    it.op           = op;
    it.edge_rising  = rising;
    it.capture_time = stamp;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    if (counting) items_sent++;
  endtask

  // Ticks carry random polarity and time bits, which the block must ignore
  task automatic tick();
    offer(OP_TICK, 1'($urandom_range(0, 1)), TIME_BITS'($urandom_range(0, 65535)));
  endtask

  // Drop valid and wait for every expected result, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Setup, access, then idle before the next transfer
  task automatic apb_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [TIME_BITS-1:0] timeout,
                            input logic [CODE_BITS-1:0] one, input logic [CODE_BITS-1:0] zero);
    wait_drained();
    apb_write(REG_TIMEOUT, DATA_BITS'(timeout));
    apb_write(REG_REPLY_ONE, DATA_BITS'(one));
    apb_write(REG_REPLY_ZRO, DATA_BITS'(zero));
    cur_timeout = timeout;
    cur_one     = one;
    cur_zero    = zero;
  endtask

  // A few ticks between edges; keep them rare when the watchdog is very short
  task automatic tick_gap();
    int unsigned n;
    if (cur_timeout < 8) n = ($urandom_range(0, 7) == 0) ? 1 : 0;
    else n = $urandom_range(0, 3);
    repeat (n) tick();
  endtask

  // One low pulse on the host line: falling edge now, rising edge width later
  task automatic pulse(input logic [TIME_BITS-1:0] width);
    tick_gap();
    offer(OP_EDGE, FALLING, now_t);
    tick_gap();
    offer(OP_EDGE, RISING, now_t + width);
    now_t = now_t + width + TIME_BITS'($urandom_range(1, 600));
  endtask

  // 1T then 2T; some units are big enough that the threshold sum carries
  task automatic calibrate();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) unit_w = $urandom_range(0, 2);
    else if (r < 4) unit_w = $urandom_range(20000, 32767);
    else unit_w = $urandom_range(3, 400);
    pulse(TIME_BITS'(unit_w));
    pulse(TIME_BITS'(2 * unit_w));
  endtask

  // LSB first; short pulse for a one. Now and then hit the threshold exactly,
  // just under it, or anywhere at all.
  task automatic send_byte(input logic [7:0] b);
    int unsigned thr;
    int unsigned r;
    logic [TIME_BITS-1:0] w;
    thr = (3 * unit_w) >> 1;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 11);
      case (r)
        0:       w = TIME_BITS'(thr);
        1:       w = TIME_BITS'(thr - 1);
        2:       w = TIME_BITS'($urandom_range(0, 65535));
        default: w = b[i] ? TIME_BITS'(unit_w) : TIME_BITS'(2 * unit_w);
      endcase
      pulse(w);
    end
  endtask

  // Well-formed exchange: calibration, then bytes; a reply code is followed by
  // the two host pulses that carry the reply
  task automatic session();
    int unsigned r;
    logic [7:0] b;
    calibrate();
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 9);
      if (r < 4) b = cur_one;
      else if (r < 7) b = cur_zero;
      else b = 8'($urandom_range(0, 255));
      send_byte(b);
      if (b == cur_one || b == cur_zero) begin
        pulse(TIME_BITS'(unit_w));
        pulse(TIME_BITS'(2 * unit_w));
      end
    end
  endtask

  // Enough ticks to run a short watchdog out; a long one only sees a handful
  task automatic tick_burst();
    int unsigned n;
    if (cur_timeout <= 300) n = cur_timeout + $urandom_range(0, 4);
    else n = $urandom_range(5, 20);
    repeat (n) tick();
  endtask

  // Random edges, bare tick bursts, or a sequence broken off by the watchdog
  task automatic noise();
    counting = 1'b0;
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(4, 12))
           offer(OP_EDGE, 1'($urandom_range(0, 1)), TIME_BITS'($urandom_range(0, 65535)));
      1: tick_burst();
      default: begin
        calibrate();
        repeat ($urandom_range(1, 7)) pulse(TIME_BITS'(unit_w));
        tick_burst();
      end
    endcase
    counting = 1'b1;
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 7) session();
      else noise();
      // Sender pause: let every result come home before going on
      if ($urandom_range(0, 14) == 0) wait_drained();
    end
    quiet = 1'b0;
  endtask

  // Directed opening under the reset register values
  task automatic directed();
    logic [7:0] b;
    logic [TIME_BITS-1:0] w;
    tick();                               // watchdog not yet running
    offer(OP_EDGE, RISING, 16'hFFFF);     // wrong polarity, ignored
    offer(OP_EDGE, FALLING, 16'hFFFA);    // 1T of 10 across the timer wrap
    offer(OP_EDGE, RISING, 16'h0004);
    offer(OP_EDGE, FALLING, 16'hFFFF);    // 2T of 20, threshold 15
    offer(OP_EDGE, RISING, 16'h0013);
    unit_w = 10;
    now_t  = '0;
    b      = REPLY_ONE_RST;
    for (int i = 0; i < 8; i++) begin
      // First bit sits exactly on the threshold and must decode as zero
      w = (i == 0) ? TIME_BITS'(15) : (b[i] ? TIME_BITS'(10) : TIME_BITS'(20));
      offer(OP_EDGE, FALLING, now_t);
      offer(OP_EDGE, RISING, now_t + w);
      now_t = now_t + 16'd40;
    end
    for (int i = 0; i < 2; i++) begin
      offer(OP_EDGE, FALLING, now_t);
      offer(OP_EDGE, RISING, now_t + TIME_BITS'(10 * (i + 1)));
      now_t = now_t + 16'd40;
    end
  endtask

  initial begin : stimulus
    now_t = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    run_phase(200);

    // Shortest watchdog, codes at both ends of the byte range
    set_config(16'd1, 8'h00, 8'hFF);
    run_phase(200);

    // Longest watchdog, codes swapped; hold the receiver off for a long stretch
    set_config(16'hFFFF, 8'hFF, 8'h00);
    holds_asked++;
    run_phase(200);

    // Short watchdog that bursts can reach, random codes
    set_config(16'd40, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    holds_asked++;
    run_phase(200);

    set_config(16'($urandom_range(100, 300)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    run_phase(200);

    wait_drained();
    $display("Run covered %0d counted items over five register settings: %0d bytes, %0d replies,",
             items_sent, bytes_seen, replies_seen);
    $display("%0d watchdog expiries, two long receiver hold-offs.", expiries_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
